### sv/bms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_pkg
// shared control and tag types for the midpoint subdivision block
// ----------------------------------------------------------------------------
package bms_pkg;

   // sequencer to point store
   typedef struct packed {
      logic load;   // collect one control point
      logic rd;     // sweep read of one row entry
      logic first;  // read is the front entry of the row
      logic last;   // read is the back entry of the row
   } pt_ctl_type;

   // tag that comes back with the point store read data
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } pt_dat_type;

   // sequencer to back store
   typedef struct packed {
      logic wr;
      logic rd;
      logic fin;    // read is the original last point
   } bk_ctl_type;

   typedef struct packed {
      logic valid;
      logic fin;
   } bk_dat_type;

endpackage

### sv/bms_point_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_point_unit
// control point memory with in-place pairwise midpoint write-back
// ----------------------------------------------------------------------------
module bms_point_unit #(
   parameter int MAX_POINTS  = 16,
   parameter int COORD_WIDTH = 24,
   parameter int AW          = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bms_pkg::pt_ctl_type           ctl,
   input  logic [AW-1:0]                 load_addr,
   input  logic signed [COORD_WIDTH-1:0] load_x,
   input  logic signed [COORD_WIDTH-1:0] load_y,
   input  logic [AW-1:0]                 rd_addr,
   output bms_pkg::pt_dat_type           dat,
   output logic signed [COORD_WIDTH-1:0] dat_x,
   output logic signed [COORD_WIDTH-1:0] dat_y
);
   import bms_pkg::*;

   localparam int WW = 2 * COORD_WIDTH;

   logic [WW-1:0]          mem [MAX_POINTS];
   logic [WW-1:0]          rd_q_ff;
   logic [WW-1:0]          prev_ff;
   logic                   tag_valid_ff;
   logic                   tag_first_ff;
   logic                   tag_last_ff;
   logic [AW-1:0]          tag_addr_ff;
   logic [COORD_WIDTH:0]   sum_x;
   logic [COORD_WIDTH:0]   sum_y;
   logic [WW-1:0]          mid;

   // floor of the half sum: drop the low bit of the widened sum
   always_comb begin
      sum_x = {prev_ff[WW-1], prev_ff[WW-1:COORD_WIDTH]}
            + {rd_q_ff[WW-1], rd_q_ff[WW-1:COORD_WIDTH]};
      sum_y = {prev_ff[COORD_WIDTH-1], prev_ff[COORD_WIDTH-1:0]}
            + {rd_q_ff[COORD_WIDTH-1], rd_q_ff[COORD_WIDTH-1:0]};
      mid   = {sum_x[COORD_WIDTH:1], sum_y[COORD_WIDTH:1]};
   end

   // entry i-1 is rewritten once entry i has been read, so a level never
   // reads an entry it has already overwritten
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mem[load_addr] <= {load_x, load_y};
      end else if (tag_valid_ff && !tag_first_ff) begin
         mem[tag_addr_ff - AW'(1)] <= mid;
      end
      if (ctl.rd) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
      end else begin
         tag_valid_ff <= ctl.rd;
      end
      tag_first_ff <= ctl.first;
      tag_last_ff  <= ctl.last;
      tag_addr_ff  <= rd_addr;
      if (tag_valid_ff) begin
         prev_ff <= rd_q_ff;
      end
   end

   assign dat.valid = tag_valid_ff;
   assign dat.first = tag_first_ff;
   assign dat.last  = tag_last_ff;
   assign dat_x     = rd_q_ff[WW-1:COORD_WIDTH];
   assign dat_y     = rd_q_ff[COORD_WIDTH-1:0];

endmodule

### sv/bms_back_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_back_unit
// back point of each level, read out deepest first for the right half
// ----------------------------------------------------------------------------
module bms_back_unit #(
   parameter int MAX_POINTS  = 16,
   parameter int COORD_WIDTH = 24,
   parameter int AW          = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bms_pkg::bk_ctl_type           ctl,
   input  logic [AW-1:0]                 wr_addr,
   input  logic signed [COORD_WIDTH-1:0] wr_x,
   input  logic signed [COORD_WIDTH-1:0] wr_y,
   input  logic [AW-1:0]                 rd_addr,
   output bms_pkg::bk_dat_type           dat,
   output logic signed [COORD_WIDTH-1:0] dat_x,
   output logic signed [COORD_WIDTH-1:0] dat_y
);
   import bms_pkg::*;

   localparam int WW = 2 * COORD_WIDTH;

   logic [WW-1:0] mem [MAX_POINTS];
   logic [WW-1:0] rd_q_ff;
   logic          valid_ff;
   logic          fin_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[wr_addr] <= {wr_x, wr_y};
      end
      if (ctl.rd) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.rd;
      end
      fin_ff <= ctl.fin;
   end

   assign dat.valid = valid_ff;
   assign dat.fin   = fin_ff;
   assign dat_x     = rd_q_ff[WW-1:COORD_WIDTH];
   assign dat_y     = rd_q_ff[COORD_WIDTH-1:0];

endmodule

### sv/bezier_midpoint_subdivide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_midpoint_subdivide
// de casteljau subdivision at t = 1/2 of a fixed point bezier control polygon
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   req_x, req_y, req_last         start & !busy
//  response  rsp_out_x .. rsp_overflow      rsp_strobe, one cycle, no stall
//
//  control points are taken one a cycle while collecting; busy stays low.
//  a beat with req_last starts the run: with n stored points each level is
//  swept through the point memory read port, followed by a drain state,
//  then the back memory is read deepest level first; busy is high throughout.
//  results pass the memory read and response registers; the last one may come
//  after busy has dropped. reset clears the control state, not the memories.
// ----------------------------------------------------------------------------
module bezier_midpoint_subdivide #(
   parameter int MAX_POINTS  = 16,
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_x,
   input  logic signed [COORD_WIDTH-1:0] req_y,
   input  logic                          req_last,
   output logic                          rsp_strobe,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic                          rsp_second_curve,
   output logic                          rsp_final_res,
   output logic                          rsp_overflow
);
   import bms_pkg::*;

   localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   localparam logic [1:0] S_COLLECT = 2'd0;
   localparam logic [1:0] S_SWEEP   = 2'd1;
   localparam logic [1:0] S_DRAIN   = 2'd2;
   localparam logic [1:0] S_RIGHT   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic             ovf_seen_ff, ovf_seen_in;
   logic             ovf_run_ff, ovf_run_in;
   logic [AW-1:0]    lev_ff, lev_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    ridx_ff, ridx_in;

   logic             accept;
   logic             store_ok;
   logic [CNT_W-1:0] last_idx;
   logic             idx_at_end;
   logic             lev_at_end;

   pt_ctl_type       pt_ctl;
   pt_dat_type       pt_dat;
   bk_ctl_type       bk_ctl;
   bk_dat_type       bk_dat;
   logic signed [COORD_WIDTH-1:0] pt_x, pt_y, bk_x, bk_y;

   logic                          rsp_strobe_ff;
   logic signed [COORD_WIDTH-1:0] rsp_x_ff, rsp_y_ff;
   logic                          rsp_second_ff, rsp_final_ff, rsp_ovf_ff;

   assign busy     = (state_ff != S_COLLECT);
   assign accept   = start && !busy;
   assign store_ok = (count_ff < CNT_W'(MAX_POINTS));
   assign last_idx   = n_ff - CNT_W'(1) - CNT_W'(lev_ff);
   assign idx_at_end = (CNT_W'(idx_ff) == last_idx);
   assign lev_at_end = (CNT_W'(lev_ff) == n_ff - CNT_W'(1));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      n_in        = n_ff;
      ovf_seen_in = ovf_seen_ff;
      ovf_run_in  = ovf_run_ff;
      lev_in      = lev_ff;
      idx_in      = idx_ff;
      ridx_in     = ridx_ff;
      pt_ctl      = '0;
      bk_ctl      = '0;

      pt_ctl.load = accept && store_ok;
      // the arrival of a level's back entry always lands in the drain cycle
      bk_ctl.wr   = pt_dat.valid && pt_dat.last;

      unique case (state_ff)
         S_COLLECT: begin
            if (accept) begin
               if (store_ok) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_seen_in = 1'b1;
               end
               if (req_last) begin
                  n_in        = count_ff + CNT_W'(store_ok);
                  ovf_run_in  = ovf_seen_ff || !store_ok;
                  count_in    = '0;
                  ovf_seen_in = 1'b0;
                  lev_in      = '0;
                  idx_in      = '0;
                  state_in    = S_SWEEP;
               end
            end
         end
         S_SWEEP: begin
            pt_ctl.rd    = 1'b1;
            pt_ctl.first = (idx_ff == '0);
            pt_ctl.last  = idx_at_end;
            if (idx_at_end) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            // a gap state so the next level reads the rewritten row
            idx_in = '0;
            if (lev_at_end) begin
               ridx_in  = lev_ff;
               state_in = S_RIGHT;
            end else begin
               lev_in   = lev_ff + AW'(1);
               state_in = S_SWEEP;
            end
         end
         S_RIGHT: begin
            bk_ctl.rd  = 1'b1;
            bk_ctl.fin = (ridx_ff == '0);
            if (ridx_ff == '0) begin
               state_in = S_COLLECT;
            end else begin
               ridx_in = ridx_ff - AW'(1);
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_COLLECT;
         count_ff    <= '0;
         ovf_seen_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_seen_ff <= ovf_seen_in;
      end
      n_ff       <= n_in;
      ovf_run_ff <= ovf_run_in;
      lev_ff     <= lev_in;
      idx_ff     <= idx_in;
      ridx_ff    <= ridx_in;
   end

   bms_point_unit #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH),
      .AW          (AW)
   ) u_point (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pt_ctl),
      .load_addr (count_ff[AW-1:0]),
      .load_x    (req_x),
      .load_y    (req_y),
      .rd_addr   (idx_ff),
      .dat       (pt_dat),
      .dat_x     (pt_x),
      .dat_y     (pt_y)
   );

   bms_back_unit #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH),
      .AW          (AW)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .ctl     (bk_ctl),
      .wr_addr (lev_ff),
      .wr_x    (pt_x),
      .wr_y    (pt_y),
      .rd_addr (ridx_ff),
      .dat     (bk_dat),
      .dat_x   (bk_x),
      .dat_y   (bk_y)
   );

   // left beats come from row fronts, right beats from the back memory
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (pt_dat.valid && pt_dat.first) || bk_dat.valid;
      end
      rsp_x_ff      <= bk_dat.valid ? bk_x : pt_x;
      rsp_y_ff      <= bk_dat.valid ? bk_y : pt_y;
      rsp_second_ff <= bk_dat.valid;
      rsp_final_ff  <= bk_dat.valid && bk_dat.fin;
      rsp_ovf_ff    <= ovf_run_ff;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_second_curve = rsp_second_ff;
   assign rsp_final_res    = rsp_final_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_no_read_clash: assert property (@(posedge clock) disable iff (reset)
      !(pt_dat.valid && bk_dat.valid))
      else $error("point and back reads returned together");

   a_final_right: assert property (@(posedge clock) disable iff (reset)
      rsp_final_res |-> (rsp_strobe && rsp_second_curve))
      else $error("final beat outside the right half");

   a_collect_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COLLECT) |-> !pt_ctl.rd && !bk_ctl.rd)
      else $error("memory read while collecting");

endmodule
